FILE: rtl/aabb_pkg.sv
// Shared definitions for the axis-aligned box unit: default widths,
// operation codes and the stage advance bundle. No dependencies.
package aabb_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OP_BITS        = 3;

  localparam logic [OP_BITS-1:0] OP_SET_BOX   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_EXTEND    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_CONTAINS  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_FULL      = 3'd3;
  localparam logic [OP_BITS-1:0] OP_INTERSECT = 3'd4;

  localparam int AXES = 3;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic so;
  } aabb_adv_t;

endpackage

FILE: rtl/aabb_lane.sv
// One axis of the slab test: corner-minus-origin, product with the inverse
// direction, truncating shift with saturation, and near/far ordering.
// Depends on aabb_pkg.
module aabb_lane #(
  parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = aabb_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  aabb_pkg::aabb_adv_t          adv,
  input  logic signed [COORD_BITS-1:0] box_lo,
  input  logic signed [COORD_BITS-1:0] box_hi,
  input  logic signed [COORD_BITS-1:0] org,
  input  logic signed [COORD_BITS-1:0] inv,
  output logic signed [COORD_BITS-1:0] t_near,
  output logic signed [COORD_BITS-1:0] t_far
);

  localparam int PW = 2 * COORD_BITS + 1;
  localparam logic [PW-1:0] RND = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MAX_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MIN_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS:0]   d_a;
  logic signed [COORD_BITS:0]   d_b;
  logic signed [COORD_BITS-1:0] inv_r;
  logic signed [PW-1:0]         prod_a;
  logic signed [PW-1:0]         prod_b;
  logic signed [COORD_BITS-1:0] sc_a;
  logic signed [COORD_BITS-1:0] sc_b;

  function automatic logic signed [COORD_BITS-1:0] scale(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] sh;
    logic [PW-COORD_BITS:0] top;
    adj = v + (v[PW-1] ? $signed(RND) : $signed({PW{1'b0}}));
    sh  = adj >>> FRAC_BITS;
    top = sh[PW-1:COORD_BITS-1];
    if ((&top) || !(|top)) begin
      return sh[COORD_BITS-1:0];
    end
    return sh[PW-1] ? MIN_NEG : MAX_POS;
  endfunction

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      d_a   <= {box_lo[COORD_BITS-1], box_lo} - {org[COORD_BITS-1], org};
      d_b   <= {box_hi[COORD_BITS-1], box_hi} - {org[COORD_BITS-1], org};
      inv_r <= inv;
    end
    if (adv.s2) begin
      prod_a <= d_a * inv_r;
      prod_b <= d_b * inv_r;
    end
    if (adv.s3) begin
      t_near <= (sc_b < sc_a) ? sc_b : sc_a;
      t_far  <= (sc_a < sc_b) ? sc_b : sc_a;
    end
  end

  always_comb begin
    sc_a = scale(prod_a);
    sc_b = scale(prod_b);
  end

endmodule

FILE: rtl/aabb_merge.sv
// Merge of the three axis lanes: entry and exit distance, hit decision
// and the result register. Depends on aabb_pkg.
module aabb_merge #(
  parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  aabb_pkg::aabb_adv_t                   adv,
  input  logic                                  is_ray,
  input  logic                                  pre_hit,
  input  logic [aabb_pkg::AXES-1:0][COORD_BITS-1:0] t_near,
  input  logic [aabb_pkg::AXES-1:0][COORD_BITS-1:0] t_far,
  output logic                                  hit,
  output logic signed [COORD_BITS-1:0]          distance
);

  logic signed [COORD_BITS-1:0] m01;
  logic signed [COORD_BITS-1:0] tmin;
  logic signed [COORD_BITS-1:0] x01;
  logic signed [COORD_BITS-1:0] tmax;
  logic                         ray_hit;

  always_comb begin
    m01 = ($signed(t_near[0]) < $signed(t_near[1])) ? t_near[1] : t_near[0];
    tmin = (m01 < $signed(t_near[2])) ? t_near[2] : m01;
    x01 = ($signed(t_far[1]) < $signed(t_far[0])) ? t_far[1] : t_far[0];
    tmax = ($signed(t_far[2]) < x01) ? t_far[2] : x01;
    ray_hit = !tmax[COORD_BITS-1] && !(tmax < tmin);
  end

  always_ff @(posedge clk) begin
    if (adv.so) begin
      hit      <= is_ray ? ray_hit : pre_hit;
      distance <= (is_ray && ray_hit) ? tmin : '0;
    end
  end

endmodule

FILE: rtl/aabb_extend_contain_ray_slab_unit.sv
// Top level of the axis-aligned box unit: box registers, point tests,
// three slab lanes and the merge stage. Depends on aabb_pkg, aabb_lane, aabb_merge.
//
// The unit holds one 3-D box in signed fixed point and takes one operation per
// transfer: set_box, extend, contains, fully_contains or a ray slab intersect.
// It sustains one item per clock while m_tready does not stall the output;
// each result passes through the three lane stages (difference, multiply,
// scale) and the merge register. Box updates take effect at the input
// transfer, so a following item always sees them. Reset leaves an empty box.
module aabb_extend_contain_ray_slab_unit #(
  parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = aabb_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // op, p_x, p_y, p_z, q_x, q_y, q_z, inv_dir_x, inv_dir_y, inv_dir_z
  input  logic [((aabb_pkg::OP_BITS + 9 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hit, distance
  output logic [((1 + COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int AX = aabb_pkg::AXES;
  localparam int OB = aabb_pkg::OP_BITS;
  localparam int OUT_W = ((1 + COORD_BITS + 7) / 8) * 8;
  localparam logic signed [COORD_BITS-1:0] MAX_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MIN_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [OB-1:0]                op;
  logic signed [COORD_BITS-1:0] p [AX];
  logic signed [COORD_BITS-1:0] q [AX];
  logic signed [COORD_BITS-1:0] inv [AX];
  logic signed [COORD_BITS-1:0] box_min [AX];
  logic signed [COORD_BITS-1:0] box_max [AX];
  logic [AX-1:0][COORD_BITS-1:0] t_near;
  logic [AX-1:0][COORD_BITS-1:0] t_far;

  aabb_pkg::aabb_adv_t adv;
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, out_rdy;
  logic ray1, ray2, ray3;
  logic hit1, hit2, hit3;
  logic in_p, in_q, pre_hit;
  logic hit;
  logic signed [COORD_BITS-1:0] distance;
  logic accept;

  always_comb begin
    op = s_tdata[OB-1:0];
    for (int i = 0; i < AX; i++) begin
      p[i]   = s_tdata[OB + i * COORD_BITS +: COORD_BITS];
      q[i]   = s_tdata[OB + (AX + i) * COORD_BITS +: COORD_BITS];
      inv[i] = s_tdata[OB + (2 * AX + i) * COORD_BITS +: COORD_BITS];
    end
  end

  always_comb begin
    out_rdy  = !m_tvalid || m_tready;
    rdy3     = !v3 || out_rdy;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    s_tready = rdy1;
    adv.s1   = s_tvalid && rdy1;
    adv.s2   = v1 && rdy2;
    adv.s3   = v2 && rdy3;
    adv.so   = v3 && out_rdy;
    accept   = adv.s1;
  end

  always_comb begin
    in_p = 1'b1;
    in_q = 1'b1;
    for (int i = 0; i < AX; i++) begin
      in_p = in_p && !(p[i] < box_min[i]) && !(box_max[i] < p[i]);
      in_q = in_q && !(q[i] < box_min[i]) && !(box_max[i] < q[i]);
    end
    unique case (op)
      aabb_pkg::OP_CONTAINS: pre_hit = in_p;
      aabb_pkg::OP_FULL:     pre_hit = in_p && in_q;
      default:               pre_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AX; i++) begin
        box_min[i] <= MAX_POS;
        box_max[i] <= MIN_NEG;
      end
    end else if (accept) begin
      unique case (op)
        aabb_pkg::OP_SET_BOX: begin
          for (int i = 0; i < AX; i++) begin
            box_min[i] <= p[i];
            box_max[i] <= q[i];
          end
        end
        aabb_pkg::OP_EXTEND: begin
          for (int i = 0; i < AX; i++) begin
            if (p[i] < box_min[i]) box_min[i] <= p[i];
            if (box_max[i] < p[i]) box_max[i] <= p[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (out_rdy) m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ray1 <= (op == aabb_pkg::OP_INTERSECT);
      hit1 <= pre_hit;
    end
    if (adv.s2) begin
      ray2 <= ray1;
      hit2 <= hit1;
    end
    if (adv.s3) begin
      ray3 <= ray2;
      hit3 <= hit2;
    end
  end

  for (genvar g = 0; g < AX; g++) begin : g_lane
    aabb_lane #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .adv   (adv),
      .box_lo(box_min[g]),
      .box_hi(box_max[g]),
      .org   (p[g]),
      .inv   (inv[g]),
      .t_near(t_near[g]),
      .t_far (t_far[g])
    );
  end

  aabb_merge #(
    .COORD_BITS(COORD_BITS)
  ) u_merge (
    .clk     (clk),
    .adv     (adv),
    .is_ray  (ray3),
    .pre_hit (hit3),
    .t_near  (t_near),
    .t_far   (t_far),
    .hit     (hit),
    .distance(distance)
  );

  assign m_tdata = {{(OUT_W - 1 - COORD_BITS){1'b0}}, distance, hit};

  a_set_box: assert property (@(posedge clk) disable iff (rst)
    accept && op == aabb_pkg::OP_SET_BOX |=>
      box_min[0] == $past(p[0]) && box_max[0] == $past(q[0]))
    else $error("set_box did not load the corners");

  a_extend: assert property (@(posedge clk) disable iff (rst)
    accept && op == aabb_pkg::OP_EXTEND |=>
      !($past(p[1]) < box_min[1]) && !(box_max[1] < $past(p[1])))
    else $error("extend did not take in the point");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> distance == '0)
    else $error("miss with nonzero distance");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |-> $past(v3))
    else $error("result without an item in flight");

endmodule
